FILE: hw/rtl/ebfd_pkg.sv
package ebfd_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int ANGLE_BITS  = 21;
    localparam int STATUS_BITS = 3;
    localparam int ERR_BITS    = 2;
    localparam int POS_BITS    = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 3;

    localparam int ANGLE_HI_SHIFT  = 13;
    localparam int ANGLE_MID_SHIFT = 5;
    localparam int ANGLE_LO_SHIFT  = 3;

    localparam logic [BYTE_BITS-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_BITS-1:0] CRC_TOP  = 8'h80;

    localparam logic [POS_BITS-1:0] POS_HDR0  = 3'd0;
    localparam logic [POS_BITS-1:0] POS_HDR1  = 3'd1;
    localparam logic [POS_BITS-1:0] POS_ANG_HI  = 3'd2;
    localparam logic [POS_BITS-1:0] POS_ANG_MID = 3'd3;
    localparam logic [POS_BITS-1:0] POS_ANG_LO  = 3'd4;
    localparam logic [POS_BITS-1:0] POS_CRC   = 3'd5;
    localparam logic [POS_BITS-1:0] POS_IDLE  = 3'd6;

    localparam logic [CFG_IDX_BITS-1:0] REG_CRC_CHECK_ENABLE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEAK_FIELD_MASK  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNDERVOLT_MASK   = 2'd2;

    localparam logic [ERR_BITS-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_CRC       = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_WEAK      = 2'd2;
    localparam logic [ERR_BITS-1:0] ERR_UNDERVOLT = 2'd3;

    typedef struct packed {
        logic                   crc_check_enable;
        logic [STATUS_BITS-1:0] weak_field_mask;
        logic [STATUS_BITS-1:0] undervolt_mask;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]  angle;
        logic [STATUS_BITS-1:0] status_bits;
        logic [BYTE_BITS-1:0]   rx_crc;
        logic [BYTE_BITS-1:0]   calc_crc;
        logic [ERR_BITS-1:0]    error_code;
    } result_t;

    function automatic logic [BYTE_BITS-1:0] crc8_byte(
        input logic [BYTE_BITS-1:0] crc,
        input logic [BYTE_BITS-1:0] b
    );
        logic [BYTE_BITS-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_BITS; k++)
        begin
            if ((c & CRC_TOP) != '0)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/ebfd_rx_if.sv
interface ebfd_rx_if #(parameter int TIMESTAMP_BITS = 16);
    logic                      valid;
    logic                      ready;
    logic [7:0]                rx_byte;
    logic                      frame_start;
    logic [TIMESTAMP_BITS-1:0] stamp;

    modport source (output valid, rx_byte, frame_start, stamp, input ready);
    modport sink (input valid, rx_byte, frame_start, stamp, output ready);
endinterface

FILE: hw/rtl/ebfd_res_if.sv
interface ebfd_res_if #(parameter int TIMESTAMP_BITS = 16);
    logic                      valid;
    logic                      ready;
    logic [20:0]               angle;
    logic [2:0]                status_bits;
    logic [7:0]                rx_crc;
    logic [7:0]                calc_crc;
    logic [TIMESTAMP_BITS-1:0] frame_stamp;
    logic [1:0]                error_code;

    modport source (
        output valid, angle, status_bits, rx_crc, calc_crc, frame_stamp,
               error_code,
        input  ready
    );
    modport sink (
        input  valid, angle, status_bits, rx_crc, calc_crc, frame_stamp,
               error_code,
        output ready
    );
endinterface

FILE: hw/rtl/ebfd_cfg_if.sv
interface ebfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [2:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ebfd_cfg_regs.sv
module ebfd_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    ebfd_cfg_if.sink    cfg,
    output ebfd_pkg::cfg_t regs
);
    import ebfd_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CRC_CHECK_ENABLE: regs_next.crc_check_enable = cfg.data[0];
                REG_WEAK_FIELD_MASK:  regs_next.weak_field_mask  = cfg.data;
                REG_UNDERVOLT_MASK:   regs_next.undervolt_mask   = cfg.data;
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.crc_check_enable <= 1'b1;
            regs_reg.weak_field_mask  <= 3'd2;
            regs_reg.undervolt_mask   <= 3'd4;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end
endmodule

FILE: hw/rtl/ebfd_decode.sv
module ebfd_decode #(
    parameter int TIMESTAMP_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [ebfd_pkg::BYTE_BITS-1:0] rx_byte,
    input  logic                          frame_start,
    input  logic [TIMESTAMP_BITS-1:0]     stamp,
    input  ebfd_pkg::cfg_t                regs,
    output logic                          emit,
    output ebfd_pkg::result_t             result,
    output logic [TIMESTAMP_BITS-1:0]     frame_stamp
);
    import ebfd_pkg::*;

    logic [POS_BITS-1:0]       pos_reg, pos_next, pos_eff;
    logic [BYTE_BITS-1:0]      crc_reg, crc_next, crc_base;
    logic [ANGLE_BITS-1:0]     angle_reg, angle_next, angle_base;
    logic [STATUS_BITS-1:0]    status_reg, status_next, status_base;
    logic [TIMESTAMP_BITS-1:0] stamp_reg, stamp_next;
    logic [ERR_BITS-1:0]       err;

    // a frame start restarts the frame at the header byte
    assign pos_eff     = frame_start ? POS_HDR0 : pos_reg;
    assign crc_base    = frame_start ? '0 : crc_reg;
    assign angle_base  = frame_start ? '0 : angle_reg;
    assign status_base = frame_start ? '0 : status_reg;
    assign stamp_next  = frame_start ? stamp : stamp_reg;

    always_comb
    begin
        pos_next    = pos_eff;
        crc_next    = crc_base;
        angle_next  = angle_base;
        status_next = status_base;
        emit        = 1'b0;
        unique case (pos_eff)
            POS_HDR0, POS_HDR1:
            begin
                pos_next = pos_eff + 3'd1;
            end
            POS_ANG_HI:
            begin
                crc_next   = crc8_byte(crc_base, rx_byte);
                angle_next = ANGLE_BITS'({rx_byte, {ANGLE_HI_SHIFT{1'b0}}});
                pos_next   = POS_ANG_MID;
            end
            POS_ANG_MID:
            begin
                crc_next   = crc8_byte(crc_base, rx_byte);
                angle_next = angle_base |
                             ANGLE_BITS'({rx_byte, {ANGLE_MID_SHIFT{1'b0}}});
                pos_next   = POS_ANG_LO;
            end
            POS_ANG_LO:
            begin
                crc_next    = crc8_byte(crc_base, rx_byte);
                angle_next  = angle_base |
                              ANGLE_BITS'(rx_byte[BYTE_BITS-1:ANGLE_LO_SHIFT]);
                status_next = rx_byte[STATUS_BITS-1:0];
                pos_next    = POS_CRC;
            end
            POS_CRC:
            begin
                emit     = 1'b1;
                pos_next = POS_IDLE;
            end
            default:
            begin
                pos_next = pos_eff;
            end
        endcase
    end

    always_comb
    begin
        priority if (regs.crc_check_enable && (crc_base != rx_byte))
            err = ERR_CRC;
        else if ((status_base & regs.weak_field_mask) != '0)
            err = ERR_WEAK;
        else if ((status_base & regs.undervolt_mask) != '0)
            err = ERR_UNDERVOLT;
        else
            err = ERR_OK;
    end

    assign result.angle        = angle_base;
    assign result.status_bits  = status_base;
    assign result.rx_crc       = rx_byte;
    assign result.calc_crc     = crc_base;
    assign result.error_code   = err;
    assign frame_stamp         = stamp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= POS_IDLE;
        else if (take)
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            crc_reg    <= crc_next;
            angle_reg  <= angle_next;
            status_reg <= status_next;
            stamp_reg  <= stamp_next;
        end
    end
endmodule

FILE: hw/rtl/encoder_burst_frame_decoder_top.sv
// a result for byte 5 passes the input register, then is registered in the output slot once that byte is taken
// throughput: one byte per cycle while rx.ready is high, set by the combinational crc8 byte update
// rx.ready stays high unless a finished result waits and the next byte completes a frame
// reset: asynchronous active-low rst_n returns the decoder to idle, waiting for frame start
// reset loads the registers with crc check on, weak field mask 2, undervoltage mask 4
module encoder_burst_frame_decoder_top #(
    parameter int TIMESTAMP_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ebfd_rx_if.sink   rx,
    ebfd_res_if.source res,
    ebfd_cfg_if.sink  cfg
);
    import ebfd_pkg::*;

    cfg_t    regs;
    result_t result;
    logic    emit;
    logic    take;
    logic [TIMESTAMP_BITS-1:0] stamp_out;

    logic                      in_valid_reg;
    logic [BYTE_BITS-1:0]      in_byte_reg;
    logic                      in_start_reg;
    logic [TIMESTAMP_BITS-1:0] in_stamp_reg;

    logic                      out_valid_reg, out_valid_next;
    result_t                   out_result_reg;
    logic [TIMESTAMP_BITS-1:0] out_stamp_reg;

    ebfd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ebfd_decode #(
        .TIMESTAMP_BITS (TIMESTAMP_BITS)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .stamp       (in_stamp_reg),
        .regs        (regs),
        .emit        (emit),
        .result      (result),
        .frame_stamp (stamp_out)
    );

    // held byte moves on unless it makes a result and the output slot stays full
    assign take     = in_valid_reg && (!emit || !out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg  <= rx.rx_byte;
            in_start_reg <= rx.frame_start;
            in_stamp_reg <= rx.stamp;
        end
    end

    always_comb
    begin
        priority if (take && emit)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_result_reg <= result;
            out_stamp_reg  <= stamp_out;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.angle        = out_result_reg.angle;
    assign res.status_bits  = out_result_reg.status_bits;
    assign res.rx_crc       = out_result_reg.rx_crc;
    assign res.calc_crc     = out_result_reg.calc_crc;
    assign res.frame_stamp  = out_stamp_reg;
    assign res.error_code   = out_result_reg.error_code;
endmodule
